### hdl/wall_follow_pid_steering_defines.svh
// Assertion macros shared by the wall-follow steering RTL.
`ifndef WALL_FOLLOW_PID_STEERING_DEFINES_SVH
`define WALL_FOLLOW_PID_STEERING_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define WFPS_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define WFPS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/wfps_pkg.sv
// Shared types and constants for the wall-follow steering block.
package wfps_pkg;

  localparam int DIST_W    = 12;  // range reading field width
  localparam int TGT_W     = 12;
  localparam int GAIN_W    = 16;
  localparam int LIMIT_W   = 8;
  localparam int SPEED_W   = 10;
  localparam int TURN_W    = 15;
  localparam int LIN_W     = 11;
  localparam int ANG_W     = 16;
  localparam int INTEG_W   = 24;
  localparam int CNT_W     = 8;
  localparam int CFG_DW    = 16;
  localparam int CFG_AW    = 3;
  localparam int IN_DATA_W = 40;
  localparam int OUT_DATA_W = 32;

  typedef enum logic [CFG_AW-1:0] {
    CFG_TARGET     = 3'd0,
    CFG_KP         = 3'd1,
    CFG_KI         = 3'd2,
    CFG_KD         = 3'd3,
    CFG_LOST_LIMIT = 3'd4,
    CFG_CRUISE     = 3'd5,
    CFG_BACKUP     = 3'd6,
    CFG_ESCAPE     = 3'd7
  } cfg_idx_t;

  typedef enum logic [1:0] {
    MODE_ESCAPE = 2'd0,
    MODE_LOST   = 2'd1,
    MODE_FOLLOW = 2'd2
  } drive_mode_t;

  typedef struct packed {
    logic [GAIN_W-1:0] kp;
    logic [GAIN_W-1:0] ki;
    logic [GAIN_W-1:0] kd;
  } pid_gains_t;

  localparam logic [TGT_W-1:0]   RST_TARGET     = 12'd200;
  localparam logic [GAIN_W-1:0]  RST_KP         = 16'd2560;
  localparam logic [GAIN_W-1:0]  RST_KI         = 16'd0;
  localparam logic [GAIN_W-1:0]  RST_KD         = 16'd0;
  localparam logic [LIMIT_W-1:0] RST_LOST_LIMIT = 8'd75;
  localparam logic [SPEED_W-1:0] RST_CRUISE     = 10'd80;
  localparam logic [SPEED_W-1:0] RST_BACKUP     = 10'd40;
  localparam logic [TURN_W-1:0]  RST_ESCAPE     = 15'd1500;

endpackage

### hdl/wall_follow_pid_steering.sv
// A word accepted on in_ passes the input stage, then the result stage, before it shows on out_.
// Throughput: one word per cycle while out_tready holds; the loop through lost detector and PID
// state closes between the input and result registers, so words wait only on a stalled result.
// in_tready drops only when the input stage is full and the result stage is stalled.
// Reset (synchronous, rst_n low): empties both stages, clears PID and lost state, and loads
// the default configuration registers.
module wall_follow_pid_steering
  import wfps_pkg::*;
#(
  parameter int DIST_BITS = 12
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // configuration write port
  input  logic                   cfg_we,
  input  logic [CFG_AW-1:0]      cfg_addr,
  input  logic [CFG_DW-1:0]      cfg_wdata,
  // input stream
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_DATA_W-1:0]   in_tdata,   // front_mm[11:0], left_mm[23:12], right_mm[35:24]
  // result stream
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_DATA_W-1:0]  out_tdata   // linear_speed[10:0], angular_rate[26:11],
                                             // drive_mode[28:27], is_lost[29]
);

  `include "wall_follow_pid_steering_defines.svh"

  // compare width: readings masked to DIST_BITS, never wider than the field
  localparam int DW    = (DIST_BITS < DIST_W) ? DIST_BITS : DIST_W;
  localparam int ERR_W = DW + 1;

  // configuration registers
  logic [TGT_W-1:0]   target_r;
  logic [GAIN_W-1:0]  kp_r;
  logic [GAIN_W-1:0]  ki_r;
  logic [GAIN_W-1:0]  kd_r;
  logic [LIMIT_W-1:0] lost_limit_r;
  logic [SPEED_W-1:0] cruise_r;
  logic [SPEED_W-1:0] backup_r;
  logic [TURN_W-1:0]  escape_r;

  // input stage
  logic               in_valid_r,  in_valid_nxt;
  logic [DW-1:0]      front_r, left_r, right_r;

  // controller state
  logic signed [INTEG_W-1:0] integ_r,    integ_nxt;
  logic signed [ERR_W-1:0]   prev_err_r, prev_err_nxt;
  logic [CNT_W-1:0]          far_cnt_r,  far_cnt_nxt;
  logic                      lost_r,     lost_nxt;

  // result stage
  logic                      out_valid_r, out_valid_nxt;
  logic signed [LIN_W-1:0]   lin_r,  lin_nxt;
  logic signed [ANG_W-1:0]   ang_r,  ang_nxt;
  drive_mode_t               mode_r, mode_nxt;
  logic                      is_lost_r;

  logic                      move;
  logic                      in_load;
  logic [DW-1:0]             tgt;
  logic                      far;
  logic                      near;
  logic [CNT_W-1:0]          cnt_inc;
  logic signed [ERR_W-1:0]   err;
  logic signed [INTEG_W-1:0] pid_integ;
  logic signed [ANG_W-1:0]   pid_ang;
  pid_gains_t                gains;

  // the input word leaves its stage whenever the result stage is free or being drained
  assign move      = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || move;
  assign in_load   = in_tvalid && in_tready;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, is_lost_r, mode_r, ang_r, lin_r};

  assign tgt   = target_r[DW-1:0];
  assign err   = $signed({1'b0, tgt}) - $signed({1'b0, right_r});
  assign gains = '{kp: kp_r, ki: ki_r, kd: kd_r};

  wfps_pid #(
    .ERR_W (ERR_W)
  ) u_pid (
    .gains     (gains),
    .err       (err),
    .prev_err  (prev_err_r),
    .integ_sum (integ_r),
    .integ_nxt (pid_integ),
    .ang       (pid_ang)
  );

  always_comb begin
    // lost detector: all three far counts up, front or right near clears
    far     = (front_r > tgt) && (right_r > tgt) && (left_r > tgt);
    near    = (front_r < tgt) || (right_r < tgt);
    cnt_inc = (far_cnt_r == {CNT_W{1'b1}}) ? far_cnt_r : far_cnt_r + 1'b1;

    far_cnt_nxt = far_cnt_r;
    lost_nxt    = lost_r;
    if (far) begin
      far_cnt_nxt = cnt_inc;
      lost_nxt    = lost_r || (cnt_inc >= lost_limit_r);
    end else if (near) begin
      far_cnt_nxt = '0;
      lost_nxt    = 1'b0;
    end

    // mode select; PID state advances only while following the wall
    integ_nxt    = integ_r;
    prev_err_nxt = prev_err_r;
    if (front_r < tgt) begin
      mode_nxt = MODE_ESCAPE;
      lin_nxt  = -$signed({1'b0, backup_r});
      ang_nxt  = $signed({1'b0, escape_r});
    end else if (lost_nxt) begin
      mode_nxt = MODE_LOST;
      lin_nxt  = $signed({1'b0, cruise_r});
      ang_nxt  = '0;
    end else begin
      mode_nxt     = MODE_FOLLOW;
      lin_nxt      = $signed({1'b0, cruise_r});
      ang_nxt      = pid_ang;
      integ_nxt    = pid_integ;
      prev_err_nxt = err;
    end

    // handshake bookkeeping
    in_valid_nxt = in_tready ? in_tvalid : in_valid_r;
    if (move) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
      integ_r      <= '0;
      prev_err_r   <= '0;
      far_cnt_r    <= '0;
      lost_r       <= 1'b0;
      target_r     <= RST_TARGET;
      kp_r         <= RST_KP;
      ki_r         <= RST_KI;
      kd_r         <= RST_KD;
      lost_limit_r <= RST_LOST_LIMIT;
      cruise_r     <= RST_CRUISE;
      backup_r     <= RST_BACKUP;
      escape_r     <= RST_ESCAPE;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (move) begin
        integ_r    <= integ_nxt;
        prev_err_r <= prev_err_nxt;
        far_cnt_r  <= far_cnt_nxt;
        lost_r     <= lost_nxt;
      end
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_addr))
          CFG_TARGET:     target_r     <= cfg_wdata[TGT_W-1:0];
          CFG_KP:         kp_r         <= cfg_wdata[GAIN_W-1:0];
          CFG_KI:         ki_r         <= cfg_wdata[GAIN_W-1:0];
          CFG_KD:         kd_r         <= cfg_wdata[GAIN_W-1:0];
          CFG_LOST_LIMIT: lost_limit_r <= cfg_wdata[LIMIT_W-1:0];
          CFG_CRUISE:     cruise_r     <= cfg_wdata[SPEED_W-1:0];
          CFG_BACKUP:     backup_r     <= cfg_wdata[SPEED_W-1:0];
          CFG_ESCAPE:     escape_r     <= cfg_wdata[TURN_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // payload registers: capture readings masked to DIST_BITS, load results on advance
  always_ff @(posedge clk) begin
    if (in_load) begin
      front_r <= in_tdata[DW-1:0];
      left_r  <= in_tdata[DIST_W+DW-1:DIST_W];
      right_r <= in_tdata[2*DIST_W+DW-1:2*DIST_W];
    end
    if (move) begin
      lin_r     <= lin_nxt;
      ang_r     <= ang_nxt;
      mode_r    <= mode_nxt;
      is_lost_r <= lost_nxt;
    end
  end

  // a set lost flag always comes with a nonzero far count
  `WFPS_ASSERT_IMPL(a_lost_has_count, lost_r, far_cnt_r != '0, "lost flag without far count")

  // a lost word can only be a lost-search command, and that one never turns
  `WFPS_ASSERT_IMPL(a_lost_word_mode, out_valid_r && is_lost_r, mode_r == MODE_LOST, "lost word not in lost mode")
  `WFPS_ASSERT_IMPL(a_lost_no_turn, out_valid_r && (mode_r == MODE_LOST), ang_r == '0, "lost mode with nonzero turn")

  // PID state holds across escape and lost words
  `WFPS_ASSERT_NEXT(a_pid_hold, move && (mode_nxt != MODE_FOLLOW), (integ_r == $past(integ_r)) && (prev_err_r == $past(prev_err_r)), "PID state moved outside follow mode")

  // back-pressure only when both stages are full and the result is stalled
  `WFPS_ASSERT_IMPL(a_ready_cause, !in_tready, in_valid_r && out_valid_r && !out_tready, "input stalled without cause")

endmodule

### hdl/wfps_pid.sv
// PID datapath: integral saturation, three gain products, Q8.8 floor and output clamp.
module wfps_pid
  import wfps_pkg::*;
#(
  parameter int ERR_W = 13
) (
  input  pid_gains_t                 gains,
  input  logic signed [ERR_W-1:0]    err,
  input  logic signed [ERR_W-1:0]    prev_err,
  input  logic signed [INTEG_W-1:0]  integ_sum,
  output logic signed [INTEG_W-1:0]  integ_nxt,
  output logic signed [ANG_W-1:0]    ang
);

  localparam int DER_W = ERR_W + 1;
  localparam int PKP_W = GAIN_W + 1 + ERR_W;
  localparam int PKI_W = GAIN_W + 1 + INTEG_W;
  localparam int PKD_W = GAIN_W + 1 + DER_W;
  localparam int ACC_W = PKI_W + 2;
  localparam int Q_W   = ACC_W - 8;

  logic signed [DER_W-1:0]     der;
  logic signed [INTEG_W:0]     integ_wide;
  logic signed [PKP_W-1:0]     p_kp;
  logic signed [PKI_W-1:0]     p_ki;
  logic signed [PKD_W-1:0]     p_kd;
  logic signed [ACC_W-1:0]     acc;
  logic signed [Q_W-1:0]       q;
  logic                        sat_hi;
  logic                        sat_lo;

  always_comb begin
    der        = DER_W'(err) - DER_W'(prev_err);
    integ_wide = (INTEG_W+1)'(integ_sum) + (INTEG_W+1)'(err);
    // clamp to the 24-bit signed range when the top two bits disagree
    if (integ_wide[INTEG_W] != integ_wide[INTEG_W-1]) begin
      integ_nxt = integ_wide[INTEG_W] ? {1'b1, {(INTEG_W-1){1'b0}}}
                                      : {1'b0, {(INTEG_W-1){1'b1}}};
    end else begin
      integ_nxt = integ_wide[INTEG_W-1:0];
    end

    p_kp = $signed({1'b0, gains.kp}) * err;
    p_ki = $signed({1'b0, gains.ki}) * integ_nxt;
    p_kd = $signed({1'b0, gains.kd}) * der;
    acc  = ACC_W'(p_kp) + ACC_W'(p_ki) + ACC_W'(p_kd);

    // arithmetic shift gives floor division by 256
    q      = acc[ACC_W-1:8];
    sat_hi = !q[Q_W-1] && (|q[Q_W-2:ANG_W-1]);
    sat_lo =  q[Q_W-1] && !(&q[Q_W-2:ANG_W-1]);
    if (sat_hi) begin
      ang = {1'b0, {(ANG_W-1){1'b1}}};
    end else if (sat_lo) begin
      ang = {1'b1, {(ANG_W-1){1'b0}}};
    end else begin
      ang = q[ANG_W-1:0];
    end
  end

endmodule

### tb/tb_top.sv
// Self-checking testbench for the wall-follow PID steering block.
module tb_top;
  import wfps_pkg::*;

  // Overall run limit in time units (clock period is 2).
  localparam int RUN_LIMIT = 400_000;
  localparam int MAX_READING = (1 << DIST_W) - 1;

  // Register image kept alongside the block, one field per register.
  typedef struct packed {
    logic [TGT_W-1:0]   target;
    logic [GAIN_W-1:0]  kp;
    logic [GAIN_W-1:0]  ki;
    logic [GAIN_W-1:0]  kd;
    logic [LIMIT_W-1:0] lost_limit;
    logic [SPEED_W-1:0] cruise;
    logic [SPEED_W-1:0] backup;
    logic [TURN_W-1:0]  escape;
  } steer_cfg_t;

  // One drive command as it leaves the block.
  typedef struct packed {
    logic signed [LIN_W-1:0] lin;
    logic signed [ANG_W-1:0] ang;
    drive_mode_t             mode;
    logic                    lost;
  } steer_cmd_t;

  localparam steer_cfg_t DEFAULT_CFG = '{RST_TARGET, RST_KP, RST_KI, RST_KD,
                                         RST_LOST_LIMIT, RST_CRUISE, RST_BACKUP,
                                         RST_ESCAPE};

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_AW-1:0]     cfg_addr = '0;
  logic [CFG_DW-1:0]     cfg_wdata = '0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;   // front_mm[11:0], left_mm[23:12], right_mm[35:24]
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;       // linear_speed[10:0], angular_rate[26:11],
                                          // drive_mode[28:27], is_lost[29]

  // Mirror of configuration and of the controller state.
  steer_cfg_t cfg_now = DEFAULT_CFG;
  int         pid_integral = 0;
  int         pid_prev_err = 0;
  int         far_ticks = 0;
  bit         lost_state = 1'b0;

  // Commands still owed by the block, oldest first.
  steer_cmd_t expected_cmds[$];

  bit idle_on = 1'b1;
  int mismatch_count = 0;
  int words_sent = 0;
  int words_checked = 0;
  int settings_used = 0;
  int mode_seen[3] = '{0, 0, 0};

  wall_follow_pid_steering u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Hard stop in case the block hangs on either handshake.
  initial begin
    #(RUN_LIMIT);
    $display("Timeout: %0d words sent, %0d still outstanding", words_sent,
             expected_cmds.size());
    $display("Mismatches found");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Steering predictor: lost detector first, then mode select and PID.
  // ---------------------------------------------------------------------------
  function automatic steer_cmd_t predict_command(input logic [DIST_W-1:0] front,
                                                 input logic [DIST_W-1:0] left,
                                                 input logic [DIST_W-1:0] right);
    steer_cmd_t cmd;
    int         tgt, fv, lv, rv;
    int         err, deriv, integ;
    longint     acc, quot;
    tgt = int'(cfg_now.target);
    fv  = int'(front);
    lv  = int'(left);
    rv  = int'(right);

    // Far on all sides counts toward lost; near front or right clears it;
    // anything else (a reading sitting exactly on target) holds the detector.
    if (fv > tgt && rv > tgt && lv > tgt) begin
      if (far_ticks < 255) far_ticks++;
      if (far_ticks >= int'(cfg_now.lost_limit)) lost_state = 1'b1;
    end else if (fv < tgt || rv < tgt) begin
      far_ticks  = 0;
      lost_state = 1'b0;
    end

    if (fv < tgt) begin
      cmd.mode = MODE_ESCAPE;
      cmd.lin  = LIN_W'(-int'(cfg_now.backup));
      cmd.ang  = ANG_W'(int'(cfg_now.escape));
    end else if (lost_state) begin
      cmd.mode = MODE_LOST;
      cmd.lin  = LIN_W'(int'(cfg_now.cruise));
      cmd.ang  = '0;
    end else begin
      // PID state advances only while following the wall.
      err   = tgt - rv;
      deriv = err - pid_prev_err;
      integ = pid_integral + err;
      if (integ > 8388607) integ = 8388607;
      if (integ < -8388608) integ = -8388608;
      acc = longint'(cfg_now.kp) * err + longint'(cfg_now.ki) * integ
          + longint'(cfg_now.kd) * deriv;
      quot = acc >>> 8;   // arithmetic shift rounds toward minus infinity
      if (quot > 32767) quot = 32767;
      if (quot < -32768) quot = -32768;
      pid_prev_err = err;
      pid_integral = integ;
      cmd.mode = MODE_FOLLOW;
      cmd.lin  = LIN_W'(int'(cfg_now.cruise));
      cmd.ang  = ANG_W'(quot);
    end
    cmd.lost = lost_state;
    return cmd;
  endfunction

  // ---------------------------------------------------------------------------
  // Driving side
  // ---------------------------------------------------------------------------

  // Offer one reading triple, hold it until taken, then log the expected command.
  task automatic send_reading(input logic [DIST_W-1:0] front,
                              input logic [DIST_W-1:0] left,
                              input logic [DIST_W-1:0] right);
    steer_cmd_t cmd;
    in_tdata  <= {{(IN_DATA_W - 3 * DIST_W){1'b0}}, right, left, front};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    cmd = predict_command(front, left, right);
    expected_cmds.push_back(cmd);
    mode_seen[cmd.mode]++;
    words_sent++;
    // Drop valid for a burst now and then; otherwise keep streaming.
    if (idle_on && $urandom_range(0, 7) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
  endtask

  // Stop sending and wait until every owed command has come out.
  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (expected_cmds.size() != 0) @(posedge clk);
    // Let the two pipeline stages empty out behind the last word.
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DW-1:0] value);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= value;
    @(posedge clk);
  endtask

  // Load a full register set while the block is idle.
  task automatic configure(input steer_cfg_t s);
    drain_results();
    write_reg(CFG_TARGET,     CFG_DW'(s.target));
    write_reg(CFG_KP,         s.kp);
    write_reg(CFG_KI,         s.ki);
    write_reg(CFG_KD,         s.kd);
    write_reg(CFG_LOST_LIMIT, CFG_DW'(s.lost_limit));
    write_reg(CFG_CRUISE,     CFG_DW'(s.cruise));
    write_reg(CFG_BACKUP,     CFG_DW'(s.backup));
    write_reg(CFG_ESCAPE,     CFG_DW'(s.escape));
    cfg_we  <= 1'b0;
    cfg_now = s;
    settings_used++;
  endtask

  // Random backpressure on the result side, in bursts.
  initial begin
    forever begin
      @(posedge clk);
      if (idle_on && $urandom_range(0, 9) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk);
      end
      out_tready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Checking side
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("MISMATCH at word %0d, %s: got %0d, want %0d", words_checked, what, got, want);
    mismatch_count++;
  endtask

  always @(posedge clk) begin
    steer_cmd_t              want;
    logic signed [LIN_W-1:0] got_lin;
    logic signed [ANG_W-1:0] got_ang;
    if (rst_n && out_tvalid && out_tready) begin
      got_lin = out_tdata[10:0];
      got_ang = out_tdata[26:11];
      if (expected_cmds.size() == 0) begin
        report_mismatch("word with nothing owed", out_tdata, 0);
      end else begin
        want = expected_cmds.pop_front();
        if (got_lin !== want.lin) report_mismatch("linear_speed", got_lin, want.lin);
        if (got_ang !== want.ang) report_mismatch("angular_rate", got_ang, want.ang);
        if (out_tdata[28:27] !== want.mode)
          report_mismatch("drive_mode", out_tdata[28:27], want.mode);
        if (out_tdata[29] !== want.lost) report_mismatch("is_lost", out_tdata[29], want.lost);
      end
      words_checked++;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic logic [DIST_W-1:0] reading_between(input int lo, input int hi);
    if (lo < 0) lo = 0;
    if (hi > MAX_READING) hi = MAX_READING;
    if (lo >= hi) return DIST_W'(hi < 0 ? 0 : hi);
    return DIST_W'($urandom_range(hi, lo));
  endfunction

  function automatic steer_cfg_t random_settings();
    steer_cfg_t s;
    s.target     = ($urandom_range(0, 9) == 0) ? TGT_W'($urandom_range(0, MAX_READING))
                                                : TGT_W'($urandom_range(80, 1200));
    s.kp         = GAIN_W'($urandom);
    // Keep the integral gain mostly small so the PID does not pin at the rails.
    s.ki         = ($urandom_range(0, 9) < 6) ? GAIN_W'($urandom_range(0, 64))
                                              : GAIN_W'($urandom);
    s.kd         = GAIN_W'($urandom);
    s.lost_limit = ($urandom_range(0, 3) == 0) ? LIMIT_W'($urandom)
                                               : LIMIT_W'($urandom_range(1, 12));
    s.cruise     = SPEED_W'($urandom);
    s.backup     = SPEED_W'($urandom);
    s.escape     = TURN_W'($urandom);
    return s;
  endfunction

  // Mostly well-formed driving scenes (follow, open space, obstacle), some noise.
  task automatic run_random_items(input int count);
    int sent, run_len, tgt, kind, k, rv;
    logic [DIST_W-1:0] f, l, r;
    sent = 0;
    while (sent < count) begin
      tgt  = int'(cfg_now.target);
      kind = $urandom_range(0, 99);
      if (kind < 40) begin
        // Wall following: right reading hovers around the target.
        run_len = $urandom_range(1, 40);
        for (k = 0; k < run_len; k++) begin
          f = ($urandom_range(0, 7) == 0) ? DIST_W'(tgt) : reading_between(tgt, MAX_READING);
          l = DIST_W'($urandom);
          case ($urandom_range(0, 7))
            0: r = DIST_W'(tgt);
            1: r = DIST_W'($urandom);
            default: begin
              rv = tgt + int'($urandom_range(0, 600)) - 300;
              r  = reading_between(rv, rv);
            end
          endcase
          send_reading(f, l, r);
        end
      end else if (kind < 60 && tgt < MAX_READING) begin
        // Open space: long enough to reach the lost limit most of the time.
        run_len = $urandom_range(1, int'(cfg_now.lost_limit) + 8);
        for (k = 0; k < run_len; k++) begin
          l = ($urandom_range(0, 19) == 0) ? DIST_W'(tgt) : reading_between(tgt + 1, MAX_READING);
          send_reading(reading_between(tgt + 1, MAX_READING), l,
                       reading_between(tgt + 1, MAX_READING));
        end
      end else if (kind < 80 && tgt > 0) begin
        // Obstacle ahead.
        run_len = $urandom_range(1, 8);
        for (k = 0; k < run_len; k++)
          send_reading(reading_between(0, tgt - 1), DIST_W'($urandom), DIST_W'($urandom));
      end else begin
        // Noise, with readings landing on the target now and then.
        run_len = $urandom_range(1, 10);
        for (k = 0; k < run_len; k++) begin
          f = ($urandom_range(0, 5) == 0) ? DIST_W'(tgt) : DIST_W'($urandom);
          l = ($urandom_range(0, 5) == 0) ? DIST_W'(tgt) : DIST_W'($urandom);
          r = ($urandom_range(0, 5) == 0) ? DIST_W'(tgt) : DIST_W'($urandom);
          send_reading(f, l, r);
        end
      end
      sent += run_len;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset configuration: escape and follow modes, readings on the target, extreme readings.
  task automatic test_default_modes();
    send_reading(300, 300, 200);      // right on target: detector holds, zero error
    send_reading(300, 300, 150);
    send_reading(200, 4095, 4095);    // front on target: follow, large negative error
    send_reading(100, 500, 500);      // obstacle ahead
    send_reading(0, 0, 0);
    send_reading(4095, 0, 4095);      // left near only: detector holds
    send_reading(4095, 4095, 0);
    send_reading(4095, 4095, 4095);   // first far tick
  endtask

  // Lost detector: zero limit, limit of one and two, hold on target, clear paths.
  task automatic test_lost_detector();
    steer_cfg_t s;
    s = DEFAULT_CFG;
    s.lost_limit = 0;
    s.kd         = 16'd300;
    configure(s);
    send_reading(4095, 4095, 4095);   // zero limit: first far tick sets lost
    send_reading(4095, 4095, 4095);
    send_reading(4095, 200, 4095);    // left on target: lost holds
    send_reading(4095, 4095, 100);    // right near: clear, back to following
    s.lost_limit = 1;
    configure(s);
    send_reading(3000, 3000, 3000);
    s.lost_limit = 2;
    configure(s);
    send_reading(3000, 3000, 3000);
    send_reading(3000, 3000, 3000);
    send_reading(50, 4095, 4095);     // obstacle clears lost
  endtask

  // Gains and speeds at both ends; angular rate driven into both rails.
  task automatic test_gain_saturation();
    steer_cfg_t s;
    s = '{12'd4095, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'd255, 10'd1023, 10'd1023, 15'h7FFF};
    configure(s);
    send_reading(4095, 4095, 0);      // largest positive error
    send_reading(4095, 0, 4095);      // error back to zero, large negative derivative
    send_reading(0, 0, 0);            // escape at full backup and turn rate
    s.target = 0;
    configure(s);
    send_reading(0, 4095, 4095);      // largest negative error
    send_reading(0, 0, 0);
    configure('0);
    send_reading(0, 0, 0);            // everything zero: follow with zero output
    send_reading(1, 1, 1);            // zero limit: lost at once, zero cruise
  endtask

  // Wind the integral far up with the largest error, then far down past zero.
  task automatic test_integral_windup();
    steer_cfg_t s;
    int k;
    idle_on = 1'b0;
    s = '{12'd4095, 16'd0, 16'd1, 16'd0, 8'd255, 10'd300, 10'd200, 15'd900};
    configure(s);
    for (k = 0; k < 150; k++) send_reading(4095, DIST_W'($urandom), 0);
    s.target = 0;
    configure(s);
    // Unwind through zero and keep going negative.
    for (k = 0; k < 300; k++) send_reading(0, DIST_W'($urandom), 4095);
    s.target = 4095;
    configure(s);
    for (k = 0; k < 5; k++) send_reading(4095, DIST_W'($urandom), 0);
    idle_on = 1'b1;
  endtask

  // Random scenes under a series of settings; the last phase runs without idling.
  task automatic test_random_traffic();
    steer_cfg_t s;
    int phase;
    for (phase = 0; phase < 8; phase++) begin
      case (phase)
        0: s = '{12'd4095, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'd255, 10'd1023, 10'd1023, 15'h7FFF};
        1: s = '{12'd0, 16'd0, 16'd0, 16'd0, 8'd0, 10'd0, 10'd0, 15'd0};
        2: begin
          // Long open stretches against the top limit saturate the far counter.
          s = random_settings();
          s.target     = 12'd300;
          s.lost_limit = 8'd255;
        end
        default: s = random_settings();
      endcase
      idle_on = (phase != 7);
      configure(s);
      run_random_items(135);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    test_default_modes();
    test_lost_detector();
    test_gain_saturation();
    test_integral_windup();
    test_random_traffic();
    drain_results();
    repeat (8) @(posedge clk);
    $display("Checked %0d commands over %0d register sets: %0d escape, %0d lost, %0d follow.",
             words_checked, settings_used, mode_seen[MODE_ESCAPE], mode_seen[MODE_LOST],
             mode_seen[MODE_FOLLOW]);
    $display("Integral wound far both ways; random stalls on both sides before the last phase.");
    if (mismatch_count == 0 && expected_cmds.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
